FILE: rtl/mrrc_pkg.sv
// Shared types, constants and the CRC byte step for the Modbus read-response checker.
// No dependencies; every other file imports this package.
package mrrc_pkg;

    localparam int POS_W       = 9;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [7:0]  MAX_SLAVE_ADDR = 8'd247;
    localparam logic [7:0]  FUNC_HOLDING   = 8'd3;
    localparam logic [7:0]  FUNC_INPUT     = 8'd4;
    localparam int          MIN_FRAME_BYTES = 7;
    localparam int          HEADER_BYTES    = 3;
    localparam int          OVERHEAD_BYTES  = 5;
    localparam logic [16:0] REG_SPACE       = 17'h10000;

    typedef enum logic {
        KIND_WORD   = 1'b0,
        KIND_STATUS = 1'b1
    } result_kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_LENGTH    = 3'd1,
        ST_ADDRESS   = 3'd2,
        ST_FUNCTION  = 3'd3,
        ST_BYTECOUNT = 3'd4,
        ST_CRC       = 3'd5,
        ST_RANGE     = 3'd6
    } frame_status_t;

    typedef struct packed {
        logic [7:0]  frame_byte;
        logic        end_of_frame;
        logic [15:0] start_register;
    } in_item_t;

    typedef struct packed {
        result_kind_t  result_kind;
        logic [15:0]   register_number;
        logic [15:0]   register_word;
        frame_status_t frame_status;
    } result_item_t;

    // One byte of the reflected CRC-16, bit by bit.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

endpackage

FILE: rtl/mrrc_front.sv
// Front part: accepts frame bytes, tracks position, header and CRC, and builds
// word and status results. Depends on mrrc_pkg.
module mrrc_front
    import mrrc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 255
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  in_item_t     in_item,
    output logic         res_valid,
    input  logic         res_ready,
    output result_item_t res_item
);

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME_BYTES);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       addr_reg, addr_next;
    logic [7:0]       func_reg, func_next;
    logic [7:0]       count_reg, count_next;
    logic [7:0]       hold_reg, hold_next;
    logic [15:0]      start_reg, start_next;
    logic             too_long_reg, too_long_next;

    logic             accept;
    logic             emit_word;
    logic [POS_W-1:0] data_end;
    logic [POS_W-1:0] offset;
    logic [15:0]      word_number;
    frame_status_t    status;
    logic [16:0]      range_end;

    assign in_ready = res_ready;
    assign accept   = in_valid & res_ready;
    assign data_end = POS_W'(count_reg) + POS_W'(HEADER_BYTES);
    assign offset   = pos_reg - POS_W'(HEADER_BYTES);

    always_comb begin
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        addr_next     = addr_reg;
        func_next     = func_reg;
        count_next    = count_reg;
        hold_next     = hold_reg;
        start_next    = start_reg;
        too_long_next = too_long_reg;
        emit_word     = 1'b0;
        word_number   = start_reg + 16'(offset[POS_W-1:1]);

        if (pos_reg == '0) begin
            start_next  = in_item.start_register;
        end
        crc_next = crc_byte(crc_reg, in_item.frame_byte);

        if (pos_reg >= MAX_POS) begin
            too_long_next = 1'b1;
        end else begin
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg == POS_W'(0)) begin
                addr_next = in_item.frame_byte;
            end else if (pos_reg == POS_W'(1)) begin
                func_next = in_item.frame_byte;
            end else if (pos_reg == POS_W'(2)) begin
                count_next = in_item.frame_byte;
            end else if (pos_reg < data_end) begin
                if (!offset[0]) begin
                    hold_next = in_item.frame_byte;
                end else if (!too_long_reg) begin
                    emit_word = 1'b1;
                end
            end
        end
    end

    // Status uses the frame state including the byte that closes the frame.
    assign range_end = 17'(start_next) + 17'(count_next[7:1]);

    always_comb begin
        if (too_long_next || pos_next < POS_W'(MIN_FRAME_BYTES) || pos_next > MAX_POS) begin
            status = ST_LENGTH;
        end else if (addr_next == 8'd0 || addr_next > MAX_SLAVE_ADDR) begin
            status = ST_ADDRESS;
        end else if (func_next != FUNC_HOLDING && func_next != FUNC_INPUT) begin
            status = ST_FUNCTION;
        end else if (count_next == 8'd0 || count_next[0] ||
                     pos_next != POS_W'(count_next) + POS_W'(OVERHEAD_BYTES)) begin
            status = ST_BYTECOUNT;
        end else if (crc_next != 16'h0000) begin
            status = ST_CRC;
        end else if (range_end > REG_SPACE) begin
            status = ST_RANGE;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        res_valid = accept & (in_item.end_of_frame | emit_word);
        if (in_item.end_of_frame) begin
            res_item.result_kind     = KIND_STATUS;
            res_item.register_number = 16'h0000;
            res_item.register_word   = 16'h0000;
            res_item.frame_status    = status;
        end else begin
            res_item.result_kind     = KIND_WORD;
            res_item.register_number = word_number;
            res_item.register_word   = {hold_reg, in_item.frame_byte};
            res_item.frame_status    = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && in_item.end_of_frame)) begin
            pos_reg      <= '0;
            crc_reg      <= CRC_INIT;
            addr_reg     <= '0;
            func_reg     <= '0;
            count_reg    <= '0;
            hold_reg     <= '0;
            start_reg    <= '0;
            too_long_reg <= 1'b0;
        end else if (accept) begin
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            addr_reg     <= addr_next;
            func_reg     <= func_next;
            count_reg    <= count_next;
            hold_reg     <= hold_next;
            start_reg    <= start_next;
            too_long_reg <= too_long_next;
        end
    end

endmodule

FILE: rtl/mrrc_queue.sv
// Back part: a short result queue that holds results until the result channel
// takes them. Depends on mrrc_pkg.
module mrrc_queue
    import mrrc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    output logic         not_full,
    input  result_item_t push_item,
    output logic         m_valid,
    input  logic         m_ready,
    output result_item_t m_payload
);

    result_item_t      entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              pop;

    assign not_full  = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign m_valid   = count_reg != '0;
    assign m_payload = entry_reg[rd_ptr_reg];
    assign pop       = m_valid & m_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/modbus_read_response_checker_core.sv
// Modbus RTU read-response checker: takes one frame byte per cycle, back to back,
// and returns register words and one status per frame. The front tracker forms a
// byte's result combinationally (CRC byte step, header capture and status checks),
// and the result, if any, goes through a two-entry queue, so the input keeps flowing
// for as long as the result side takes one result per cycle. Register words are
// tentative until the frame's status result reads ok.
module modbus_read_response_checker_core
    import mrrc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 255
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  in_item_t     s_payload,
    output logic         m_valid,
    input  logic         m_ready,
    output result_item_t m_payload
);

    logic         res_valid;
    logic         res_ready;
    result_item_t res_item;

    mrrc_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_payload),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    mrrc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .not_full  (res_ready),
        .push_item (res_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // The input stalls only when results are waiting at the output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

    // A result leaves the output only by being taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_valid) |-> $past(m_ready))
        else $error("result dropped without handshake");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.result_kind == KIND_STATUS) |->
            (m_payload.register_number == 16'h0000 && m_payload.register_word == 16'h0000))
        else $error("status result carries word fields");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.result_kind == KIND_WORD) |-> m_payload.frame_status == ST_OK)
        else $error("word result carries a status code");

endmodule
